FILE: hdl/multi_click_gesture_detector_top_defines.svh
// Assertion macros shared by the multi-click gesture detector.
`ifndef MULTI_CLICK_GESTURE_DETECTOR_TOP_DEFINES_SVH
`define MULTI_CLICK_GESTURE_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MCGD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("multi-click gesture detector check failed");
`define MCGD_ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
        else $error("multi-click gesture detector sequencing check failed");
`else
`define MCGD_ASSERT(label, prop)
`define MCGD_ASSERT_NEXT(label, cond, expect_next)
`endif

`endif

FILE: hdl/mcgd_pkg.sv
// Package with the word types, register codes and helper functions of the gesture detector.
`timescale 1ns / 1ps

package mcgd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 8;

    localparam int FLEX_W   = 12;
    localparam int MS_W     = 16;
    localparam int TIME_W   = 32;
    localparam int SHOWN_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FLEX_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= FLEX_W) ?
        {FLEX_W{1'b1}} : FLEX_W'((1 << SAMPLE_BITS) - 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int DOUBLE_CLICKS = 2;
    localparam int QUAD_CLICKS   = 4;

    localparam logic [FLEX_W-1:0] FLEX_THRESHOLD_RESET = 12'd2000;
    localparam logic [MS_W-1:0]   DEBOUNCE_MS_RESET    = 16'd50;
    localparam logic [MS_W-1:0]   WINDOW_MS_RESET      = 16'd600;

    localparam logic [CFG_IDX_W-1:0] REG_FLEX_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 2'd2;

    typedef enum logic [1:0] {
        GESTURE_NONE   = 2'd0,
        GESTURE_SINGLE = 2'd1,
        GESTURE_DOUBLE = 2'd2,
        GESTURE_QUAD   = 2'd3
    } gesture_t;

    typedef struct packed {
        logic              button_level;
        logic              ir_level;
        logic [FLEX_W-1:0] flex_sample;
        logic [TIME_W-1:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic               click_seen;
        logic [SHOWN_W-1:0] click_count;
        gesture_t           gesture;
    } out_word_t;

    typedef struct packed {
        logic [FLEX_W-1:0] flex_threshold;
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   window_ms;
    } cfg_t;

    function automatic gesture_t classify(input logic [COUNT_BITS-1:0] n);
        gesture_t g;
        if (n == COUNT_BITS'(1)) begin
            g = GESTURE_SINGLE;
        end
        else if (n == COUNT_BITS'(DOUBLE_CLICKS)) begin
            g = GESTURE_DOUBLE;
        end
        else if (n >= COUNT_BITS'(QUAD_CLICKS)) begin
            g = GESTURE_QUAD;
        end
        else begin
            g = GESTURE_NONE;
        end
        return g;
    endfunction

    function automatic logic [SHOWN_W-1:0] show_count(input logic [COUNT_BITS-1:0] n);
        logic [31:0] wide;
        wide = 32'(n);
        return (wide > 32'd255) ? {SHOWN_W{1'b1}} : wide[SHOWN_W-1:0];
    endfunction

endpackage

FILE: hdl/multi_click_gesture_detector_top.sv
// Top level of the multi-click gesture detector: input register, core, result register.
//
//   Channel  Direction  Handshake             Word
//   in       input      in_valid / in_stall   mcgd_pkg::in_word_t
//   out      output     out_valid / out_stall mcgd_pkg::out_word_t
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One word per cycle enters unless in_stall; results pass the input and result registers.
// The core state and the result register update together in one cycle.
// Reset clears the detector state and loads the register defaults.
// A stall on the output holds the result register and then the input register.
`timescale 1ns / 1ps
`include "multi_click_gesture_detector_top_defines.svh"

module multi_click_gesture_detector_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mcgd_pkg::in_word_t              in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mcgd_pkg::out_word_t             out_word,
    input  logic                            cfg_we,
    input  logic [mcgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcgd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mcgd_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    logic      advance;
    logic      accept;
    cfg_t      cfg;
    out_word_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    mcgd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcgd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_word_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `MCGD_ASSERT(a_gesture_clears_count,
        out_valid_reg |->
            ((out_word_reg.gesture == GESTURE_NONE) || (out_word_reg.click_count == '0)))
    `MCGD_ASSERT(a_stall_only_when_full,
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
    `MCGD_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_reg)

endmodule

FILE: hdl/mcgd_cfg.sv
// Configuration registers of the gesture detector.
`timescale 1ns / 1ps

module mcgd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mcgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcgd_pkg::CFG_DATA_W-1:0] cfg_data,
    output mcgd_pkg::cfg_t                  cfg
);
    import mcgd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FLEX_THRESHOLD: cfg_next.flex_threshold = cfg_data[FLEX_W-1:0];
                REG_DEBOUNCE_MS:    cfg_next.debounce_ms    = cfg_data[MS_W-1:0];
                REG_WINDOW_MS:      cfg_next.window_ms      = cfg_data[MS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flex_threshold <= FLEX_THRESHOLD_RESET;
            cfg_reg.debounce_ms    <= DEBOUNCE_MS_RESET;
            cfg_reg.window_ms      <= WINDOW_MS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/mcgd_core.sv
// Click detection, debounce, counting and gesture classification for one sample word.
`timescale 1ns / 1ps

module mcgd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  mcgd_pkg::in_word_t   word,
    input  mcgd_pkg::cfg_t       cfg,
    output mcgd_pkg::out_word_t  result
);
    import mcgd_pkg::*;

    logic                  button_prev_reg;
    logic                  button_prev_next;
    logic [TIME_W-1:0]     last_click_reg;
    logic [TIME_W-1:0]     last_click_next;
    logic [COUNT_BITS-1:0] clicks_reg;
    logic [COUNT_BITS-1:0] clicks_next;
    logic                  armed_reg;
    logic                  armed_next;

    logic [FLEX_W-1:0]     flex;
    logic [TIME_W-1:0]     elapsed;
    logic                  btn_click;
    logic                  sensor;
    logic                  debounced;
    logic                  sens_click;
    logic                  click;
    logic                  window_hit;
    logic [COUNT_BITS-1:0] clicks_bumped;
    gesture_t              gesture;

    always_comb
    begin
        flex      = word.flex_sample & SAMPLE_MASK;
        elapsed   = word.now_ms - last_click_reg;
        btn_click = button_prev_reg && !word.button_level;
        sensor    = !word.ir_level || (flex > cfg.flex_threshold);
        debounced = elapsed >= TIME_W'(cfg.debounce_ms);

        armed_next = armed_reg;
        sens_click = 1'b0;
        if (sensor)
        begin
            if (!armed_reg && debounced)
            begin
                armed_next = 1'b1;
                sens_click = 1'b1;
            end
        end
        else if (armed_reg && debounced)
        begin
            armed_next = 1'b0;
        end

        click = btn_click || sens_click;

        clicks_bumped   = clicks_reg;
        last_click_next = last_click_reg;
        if (click)
        begin
            if (clicks_reg != COUNT_MAX)
            begin
                clicks_bumped = clicks_reg + COUNT_BITS'(1);
            end
            last_click_next = word.now_ms;
        end

        // A click this tick restarts the window, so only a zero window can close it at once.
        window_hit = click ? (cfg.window_ms == '0) : (elapsed >= TIME_W'(cfg.window_ms));

        gesture     = GESTURE_NONE;
        clicks_next = clicks_bumped;
        if ((clicks_bumped != '0) && window_hit)
        begin
            gesture     = classify(clicks_bumped);
            clicks_next = '0;
        end

        button_prev_next = word.button_level;

        result.click_seen  = click;
        result.click_count = show_count(clicks_next);
        result.gesture     = gesture;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_prev_reg <= 1'b1;
            last_click_reg  <= '0;
            clicks_reg      <= '0;
            armed_reg       <= 1'b0;
        end
        else if (step)
        begin
            button_prev_reg <= button_prev_next;
            last_click_reg  <= last_click_next;
            clicks_reg      <= clicks_next;
            armed_reg       <= armed_next;
        end
    end

endmodule
